### rtl/bqsa_pkg.sv
// Shared constants and codes for the boolean query score accumulator.
package bqsa_pkg;

  localparam int DOC_SLOTS = 1024;
  localparam int SLOT_W    = $clog2(DOC_SLOTS);
  localparam int CNT_W     = $clog2(DOC_SLOTS + 1);

  localparam int CMD_W   = 3;
  localparam int DOC_W   = 10;
  localparam int HIT_W   = 16;
  localparam int KIND_W  = 2;
  localparam int SCORE_W = 24;
  localparam int ALU_W   = SCORE_W + 1;

  localparam logic [CMD_W-1:0] CMD_POSTING   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_END_WORD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_OR        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_END_QUERY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COUNT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCORE = 2'd2;

  // sweep operations
  typedef logic [1:0] sweep_op_t;
  localparam sweep_op_t OP_WORD  = 2'd0;
  localparam sweep_op_t OP_GROUP = 2'd1;
  localparam sweep_op_t OP_CLEAR = 2'd2;

endpackage

### rtl/boolean_query_score_accumulator.sv
// Top level of the boolean query score accumulator: sequencer, slot stores and shared adder.
//
// Usage: the host drives in_cmd, in_doc_id and in_hit_count and raises start; a
// transaction is accepted on a rising edge where start is high and busy is low.
// Every accepted transaction yields exactly one result on out_result_kind and
// out_result_value, marked by out_valid for a single cycle; the receiver cannot
// stall, so results are simply presented once.
// Posting and unknown commands answer in the cycle after acceptance; a read
// score first reads the slot memory into a register, then raises the result
// strobe. End of word, OR, end of query and clear walk every document slot
// through one shared 25-bit adder/comparator, one slot per cycle over a
// two-stage read/write-back pipeline, then finish and give the result.
// A posting may follow every cycle; a read or a sweep command keeps busy high
// until its result is issued.
// Reset (rst_n low, synchronous): control state is cleared and a clearing pass
// zeroes all three slot stores after rst_n rises, with busy high and no result
// issued.
// The slot stores are single-write, single-read arrays with registered reads.
module boolean_query_score_accumulator
  import bqsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [DOC_W-1:0]   in_doc_id,
  input  logic [HIT_W-1:0]   in_hit_count,
  output logic               out_valid,
  output logic [KIND_W-1:0]  out_result_kind,
  output logic [SCORE_W-1:0] out_result_value
);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_READ   = 2'd3;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DOC_SLOTS - 1);

  // slot stores
  logic [HIT_W-1:0]   wh_mem [DOC_SLOTS];
  logic [HIT_W-1:0]   gs_mem [DOC_SLOTS];
  logic [SCORE_W-1:0] ts_mem [DOC_SLOTS];
  logic [HIT_W-1:0]   wh_q_r;
  logic [HIT_W-1:0]   gs_q_r;
  logic [SCORE_W-1:0] ts_q_r;

  // control
  logic [1:0]         state_r, state_nxt;
  sweep_op_t          op_r, op_nxt;
  logic               resp_en_r, resp_en_nxt;
  logic               first_r, first_nxt;
  logic [SLOT_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic               wb_vld_r, wb_vld_nxt;
  logic               wb_last_r, wb_last_nxt;
  logic [SLOT_W-1:0]  wb_addr_r, wb_addr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [SCORE_W-1:0] out_value_r, out_value_nxt;

  logic               accept;
  logic               doc_ok;
  logic [SLOT_W-1:0]  doc_idx;
  logic [SLOT_W-1:0]  rd_addr;

  // shared adder: compare for AND minimum, saturating add for OR totals
  logic [ALU_W-1:0]   alu_a, alu_b, alu_sum;
  logic               alu_cin;
  logic [SCORE_W-1:0] sat_total;
  logic [CNT_W-1:0]   cnt_sum;

  logic               wh_we, gs_we, ts_we;
  logic [SLOT_W-1:0]  wh_wa;
  logic [HIT_W-1:0]   wh_wd, gs_wd;
  logic [SCORE_W-1:0] ts_wd;

  assign accept  = start && (state_r == ST_IDLE);
  assign doc_ok  = (32'(in_doc_id) < DOC_SLOTS);
  assign doc_idx = in_doc_id[SLOT_W-1:0];
  assign rd_addr = (state_r == ST_IDLE) ? doc_idx : rd_addr_r;

  always_comb begin
    if (op_r == OP_WORD) begin
      // wh - gs; bit ALU_W-1 set means wh < gs
      alu_a   = ALU_W'(wh_q_r);
      alu_b   = ~ALU_W'(gs_q_r);
      alu_cin = 1'b1;
    end else begin
      alu_a   = ALU_W'(ts_q_r);
      alu_b   = ALU_W'(gs_q_r);
      alu_cin = 1'b0;
    end
    alu_sum = alu_a + alu_b + ALU_W'(alu_cin);
  end

  assign sat_total = alu_sum[ALU_W-1] ? {SCORE_W{1'b1}} : alu_sum[SCORE_W-1:0];
  assign cnt_sum   = cnt_r + CNT_W'(op_r == OP_GROUP && wb_vld_r && sat_total != '0);

  // write ports
  always_comb begin
    wh_we = 1'b0;
    wh_wa = wb_addr_r;
    wh_wd = '0;
    gs_we = wb_vld_r;
    gs_wd = '0;
    ts_we = 1'b0;
    ts_wd = '0;
    if (wb_vld_r) begin
      wh_we = 1'b1;
      case (op_r)
        OP_WORD: begin
          gs_wd = (first_r || alu_sum[ALU_W-1]) ? wh_q_r : gs_q_r;
        end
        OP_GROUP: begin
          ts_we = 1'b1;
          ts_wd = sat_total;
        end
        default: begin
          ts_we = 1'b1;
        end
      endcase
    end else if (accept && in_cmd == CMD_POSTING && doc_ok) begin
      wh_we = 1'b1;
      wh_wa = doc_idx;
      wh_wd = in_hit_count;
    end
  end

  always_ff @(posedge clk) begin
    if (wh_we) begin
      wh_mem[wh_wa] <= wh_wd;
    end
    wh_q_r <= wh_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (gs_we) begin
      gs_mem[wb_addr_r] <= gs_wd;
    end
    gs_q_r <= gs_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ts_we) begin
      ts_mem[wb_addr_r] <= ts_wd;
    end
    ts_q_r <= ts_mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    resp_en_nxt   = resp_en_r;
    first_nxt     = first_r;
    rd_addr_nxt   = rd_addr_r;
    wb_vld_nxt    = 1'b0;
    wb_last_nxt   = 1'b0;
    wb_addr_nxt   = rd_addr_r;
    cnt_nxt       = cnt_sum;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rd_addr_nxt = '0;
          cnt_nxt     = '0;
          resp_en_nxt = 1'b1;
          case (in_cmd)
            CMD_END_WORD: begin
              state_nxt = ST_SWEEP;
              op_nxt    = OP_WORD;
            end
            CMD_OR, CMD_END_QUERY: begin
              state_nxt = ST_SWEEP;
              op_nxt    = OP_GROUP;
            end
            CMD_CLEAR: begin
              state_nxt = ST_SWEEP;
              op_nxt    = OP_CLEAR;
            end
            CMD_READ: begin
              state_nxt = ST_READ;
              rd_ok_nxt = doc_ok;
            end
            default: begin
              // posting and unknown codes: acknowledge right away
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_ACK;
              out_value_nxt = '0;
            end
          endcase
          out_kind_nxt = (in_cmd == CMD_END_QUERY) ? KIND_COUNT :
                         (in_cmd == CMD_READ) ? KIND_SCORE : KIND_ACK;
        end
      end
      ST_SWEEP: begin
        wb_vld_nxt = 1'b1;
        if (rd_addr_r == LAST_SLOT) begin
          wb_last_nxt = 1'b1;
          state_nxt   = ST_FINISH;
        end else begin
          rd_addr_nxt = rd_addr_r + 1'b1;
        end
      end
      ST_FINISH: begin
        state_nxt     = ST_IDLE;
        first_nxt     = (op_r != OP_WORD);
        out_valid_nxt = resp_en_r;
        out_value_nxt = (out_kind_r == KIND_COUNT) ? SCORE_W'(cnt_sum) : '0;
      end
      default: begin
        // ST_READ: registered total is on ts_q_r
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_ok_r ? ts_q_r : '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // reset runs the clearing pass without a result
      state_r     <= ST_SWEEP;
      op_r        <= OP_CLEAR;
      resp_en_r   <= 1'b0;
      first_r     <= 1'b1;
      rd_addr_r   <= '0;
      wb_vld_r    <= 1'b0;
      wb_last_r   <= 1'b0;
      wb_addr_r   <= '0;
      cnt_r       <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_kind_r  <= KIND_ACK;
      out_value_r <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      resp_en_r   <= resp_en_nxt;
      first_r     <= first_nxt;
      rd_addr_r   <= rd_addr_nxt;
      wb_vld_r    <= wb_vld_nxt;
      wb_last_r   <= wb_last_nxt;
      wb_addr_r   <= wb_addr_nxt;
      cnt_r       <= cnt_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
      out_kind_r  <= out_kind_nxt;
      out_value_r <= out_value_nxt;
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_result_value = out_value_r;

`ifndef SYNTHESIS
  a_idle_no_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !wb_vld_r)
    else $error("write-back pending while idle");

  a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wb_last_r |=> (state_r == ST_IDLE))
    else $error("sweep did not finish after last slot");

  a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (out_valid && out_result_kind == KIND_SCORE))
    else $error("read score did not answer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= DOC_SLOTS)
    else $error("match count exceeds slot count");

  a_group_only_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_ACK) |-> (out_result_value == '0))
    else $error("acknowledge with nonzero value");
`endif

endmodule
